/* rtl/temp_sensor_convert_average_top_macros.svh */
// assertion macros for the temperature sensor averaging block
// used by the port checker; expects clk and arst_n in scope
`ifndef TEMP_SENSOR_CONVERT_AVERAGE_TOP_MACROS_SVH
`define TEMP_SENSOR_CONVERT_AVERAGE_TOP_MACROS_SVH

// clocked check, switched off while reset is applied
`define TSCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tsca: clocked check failed");

// clocked check that also holds during reset
`define TSCA_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tsca: reset check failed");

`endif

/* rtl/tsca_pkg.sv */
// shared types and constants of the temperature sensor averaging block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsca_pkg;

	localparam int CAL_W    = 12;
	localparam int MV_W     = 12;
	localparam int SAMPLE_W = 15;
	localparam int AVG_W    = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CAL_W-1:0]           cal_t;
	typedef logic [MV_W-1:0]            mv_t;
	typedef logic signed [AVG_W-1:0]    avg_t;

	// window preset, 41.5 degrees
	localparam sample_t PRESET_TENTHS = 15'sd415;
	localparam cal_t    CAL_RESET     = 12'd1775;

endpackage

`default_nettype wire

/* rtl/tsca_cell.sv */
// one cell of the sample window: holds a sample and passes it on when the row shifts
// depends on tsca_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsca_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire tsca_pkg::sample_t d,
	output tsca_pkg::sample_t      tap_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= tsca_pkg::PRESET_TENTHS;
		end else if (shift) begin
			tap_q <= d;
		end
	end

endmodule

`default_nettype wire

/* rtl/tsca_conv.sv */
// three stage conversion of sensor millivolts to tenths of a degree
// division by the constant denominator through a reciprocal and one correction; uses tsca_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsca_conv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsca_pkg::cal_t    cal_code,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tsca_pkg::mv_t     sense_mv,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tsca_pkg::sample_t      sample
);

	localparam int CONV_DEN = 176085;
	localparam int RECIP    = 12195;    // floor(2^31 / CONV_DEN)
	localparam int SHIFT    = 31;
	localparam int MAG_W    = 31;
	localparam int RECIP_W  = 14;
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam int Q_W      = 14;
	localparam int Q_MAX    = 10000;

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	logic               neg_s1, neg_s2;
	logic [MAG_W-1:0]   mag_s1, mag_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic signed [31:0] cal_term, mv_term, total, total_abs;
	logic [Q_W-1:0]     q_est, q_fix, q_clip;
	logic [31:0]        rem;
	tsca_pkg::sample_t  mag_sample;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;
	assign out_valid = vld_s3;

	// stage 1: exact integer numerator and its magnitude
	always_comb begin
		cal_term  = $signed({20'd0, cal_code}) * 32'sd3300;
		mv_term   = $signed({20'd0, sense_mv}) * 32'sd4095;
		total     = 32'sd52825500 + 32'sd100 * (cal_term - mv_term);
		total_abs = total[31] ? -total : total;
	end

	// stage 3: estimate is exact or one short
	always_comb begin
		q_est  = prod_s2[SHIFT +: Q_W];
		rem    = 32'({1'b0, mag_s2}) - (32'(q_est) * 32'(CONV_DEN));
		q_fix  = q_est + Q_W'(rem >= 32'(CONV_DEN));
		q_clip = (q_fix > Q_W'(Q_MAX)) ? Q_W'(Q_MAX) : q_fix;
		mag_sample = tsca_pkg::sample_t'({1'b0, q_clip});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1 <= total[31];
			mag_s1 <= total_abs[MAG_W-1:0];
		end
		if (en2) begin
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(RECIP);
		end
		if (en3) begin
			sample <= neg_s2 ? -mag_sample : mag_sample;
		end
	end

endmodule

`default_nettype wire

/* rtl/tsca_avg.sv */
// three stage rounding and saturation of the window sum to whole degrees
// division by ten times the window length via an elaborated reciprocal; uses tsca_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsca_avg #(
	parameter  int WINDOW_LEN = 8,
	localparam int SUM_W      = $clog2(10000 * WINDOW_LEN + 1) + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [SUM_W-1:0] sum,
	input  wire tsca_pkg::sample_t       sample_in,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output tsca_pkg::sample_t            sample_out,
	output tsca_pkg::avg_t               avg
);

	localparam int XW    = SUM_W + 1;
	localparam int D10   = 10 * WINDOW_LEN;
	localparam int YW    = $clog2(2560 * WINDOW_LEN);
	localparam int K     = YW;
	localparam int RECIP = (1 << K) / D10;
	localparam int PW    = 2 * K;
	localparam logic signed [XW-1:0] HALF = XW'(5 * WINDOW_LEN);
	localparam logic signed [XW-1:0] LIM  = XW'(1280 * WINDOW_LEN);

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	logic               hi_s1, lo_s1, hi_s2, lo_s2;
	logic [YW-1:0]      y_s1, y_s2;
	logic [PW-1:0]      prod_s2;
	tsca_pkg::sample_t  smp_s1, smp_s2;

	logic signed [XW-1:0] x, y_full;
	logic [7:0]           q_est, q_fix;
	logic [YW:0]          rem;

	assign en3       = !vld_s3 || out_ready;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = vld_s3;

	// offset so the quotient is non-negative when in range
	always_comb begin
		x      = XW'(sum) + HALF;
		y_full = x + LIM;
	end

	always_comb begin
		q_est = prod_s2[K +: 8];
		rem   = {1'b0, y_s2} - (YW + 1)'(q_est * D10);
		q_fix = q_est + 8'(rem >= (YW + 1)'(D10));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			hi_s1  <= (x >= LIM);
			lo_s1  <= (x < -LIM);
			y_s1   <= y_full[YW-1:0];
			smp_s1 <= sample_in;
		end
		if (en2) begin
			hi_s2   <= hi_s1;
			lo_s2   <= lo_s1;
			y_s2    <= y_s1;
			smp_s2  <= smp_s1;
			prod_s2 <= PW'(y_s1) * PW'(RECIP);
		end
		if (en3) begin
			sample_out <= smp_s2;
			priority if (hi_s2) begin
				avg <= 8'sd127;
			end else if (lo_s2) begin
				avg <= -8'sd128;
			end else begin
				avg <= tsca_pkg::avg_t'({~q_fix[7], q_fix[6:0]});
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/temp_sensor_convert_average_top.sv */
// top level of the temperature sensor conversion and moving average block
// depends on tsca_pkg, tsca_conv, tsca_cell, tsca_avg
//
// channel   dir  fields (lsb first)                       transfer when
// s_*       in   tdata: sense_mv[11:0], zero pad           s_tvalid & s_tready
// m_*       out  tdata: sample_tenths[14:0], avg[22:15]    m_tvalid & m_tready
// cfg_*     in   cal_code[11:0]                            cfg_wr_en
//
// one item per cycle sustained while m_tready stays high; each item passes every stage register to m_tvalid
// the stage chain is conversion (3), window and sum (1), average (3), seven registers in all
// each stage holds only while its successor is full and stalled, so bubbles close up
// and input transfers continue while a finished result waits on m_tready
// reset loads the window with the preset and the sum with preset times window length;
// the window sits in flip-flops, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module temp_sensor_convert_average_top #(
	parameter int WINDOW_LEN = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: cal_code
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] sense_mv, [15:12] zero
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [14:0] sample_tenths, [22:15] avg_degrees, [23] zero
);

	localparam int SUM_W = $clog2(10000 * WINDOW_LEN + 1) + 1;

	// calibration register
	tsca_pkg::cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= tsca_pkg::CAL_RESET;
		end else if (cfg_wr_en) begin
			cal_q <= cfg_wr_data;
		end
	end

	// conversion pipeline
	logic              conv_vld, conv_rdy;
	tsca_pkg::sample_t conv_sample;

	tsca_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal_code  (cal_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sense_mv  (s_tdata[11:0]),
		.out_valid (conv_vld),
		.out_ready (conv_rdy),
		.sample    (conv_sample)
	);

	// window stage: row of cells plus running sum
	logic                    win_vld_s4;
	logic                    win_en;
	logic                    win_load;
	logic                    avg_rdy;
	logic signed [SUM_W-1:0] sum_q;
	tsca_pkg::sample_t       taps [WINDOW_LEN];

	assign win_en   = !win_vld_s4 || avg_rdy;
	assign conv_rdy = win_en;
	// the row only moves when a new sample enters, so the window follows the item stream
	assign win_load = win_en && conv_vld;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		tsca_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (win_load),
			.d      ((i == 0) ? conv_sample : taps[(i == 0) ? 0 : i - 1]),
			.tap_q  (taps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_s4 <= 1'b0;
			sum_q      <= SUM_W'(415 * WINDOW_LEN);
		end else begin
			if (win_en) win_vld_s4 <= conv_vld;
			// oldest sample drops out of the last cell as the new one enters the first
			if (win_load) sum_q <= sum_q - SUM_W'(taps[WINDOW_LEN-1]) + SUM_W'(conv_sample);
		end
	end

	// average, rounding and saturation
	tsca_pkg::sample_t out_sample;
	tsca_pkg::avg_t    out_avg;

	tsca_avg #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (win_vld_s4),
		.in_ready   (avg_rdy),
		.sum        (sum_q),
		.sample_in  (taps[0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sample_out (out_sample),
		.avg        (out_avg)
	);

	assign m_tdata = {1'b0, out_avg, out_sample};

endmodule

`default_nettype wire

/* rtl/tsca_checker.sv */
// port level checks of the temperature sensor averaging block, bound to the top level
// depends on temp_sensor_convert_average_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "temp_sensor_convert_average_top_macros.svh"

module tsca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// items taken in but not yet handed out
	logic [3:0] inflight_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else begin
			inflight_q <= inflight_q + 4'(in_xfer) - 4'(out_xfer);
		end
	end

	`TSCA_ASSERT_RST(a_reset_quiet, !arst_n |-> !m_tvalid)
	`TSCA_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	`TSCA_ASSERT(a_ready_passes, !m_tvalid || m_tready |-> s_tready)
	`TSCA_ASSERT(a_depth_bound, inflight_q <= 4'd7)
	`TSCA_ASSERT(a_no_phantom, inflight_q == 4'd0 |-> !m_tvalid)

endmodule

bind temp_sensor_convert_average_top tsca_checker u_tsca_checker (.*);

`default_nettype wire
